// ===== rtl/sstn_pkg.sv =====
// Package for the sorted score table: entry and result types, status and
// action codes, the capacity default and the name canonicalization function.
// No dependencies.
`default_nettype none

package sstn_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_MATCH     = 3'd3,
    STATUS_NOMATCH   = 3'd4
  } status_e;

  typedef struct packed {
    logic [63:0] head;
    logic [7:0]  tail;
  } name_t;

  typedef struct packed {
    logic signed [31:0] score;
    name_t              name;
  } entry_t;

  // Per-cycle command shared by every cell of the row.
  typedef struct packed {
    logic rotate;
    logic insert;
  } cell_ctrl_t;

  typedef struct packed {
    status_e status;
    name_t   self_name;
    logic    has_prev;
    name_t   prev_name;
    logic    has_next;
    name_t   next_name;
    logic    last;
  } result_t;

  // Zero every byte from the first zero byte onward.
  function automatic name_t canon_name(logic [63:0] head, logic [7:0] tail);
    name_t res;
    logic  ended;
    ended = 1'b0;
    res.head = '0;
    for (int i = 0; i < 8; i++) begin
      if (head[63-8*i -: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res.head[63-8*i -: 8] = head[63-8*i -: 8];
      end
    end
    res.tail = ended ? 8'd0 : tail;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sstn_if.sv =====
// Valid/ready channel interfaces for the sorted score table: the input
// channel (add or query) and the result channel. Depends on nothing.
`default_nettype none

interface sstn_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] score;
  logic [63:0]        name_head;
  logic [7:0]         name_tail;

  modport source (output valid, action, score, name_head, name_tail, input ready);
  modport sink   (input valid, action, score, name_head, name_tail, output ready);
endinterface

interface sstn_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] self_head;
  logic [7:0]  self_tail;
  logic        has_prev;
  logic [63:0] prev_head;
  logic [7:0]  prev_tail;
  logic        has_next;
  logic [63:0] next_head;
  logic [7:0]  next_tail;
  logic        last_result;

  modport source (output valid, status, self_head, self_tail, has_prev, prev_head,
                  prev_tail, has_next, next_head, next_tail, last_result,
                  input ready);
  modport sink   (input valid, status, self_head, self_tail, has_prev, prev_head,
                  prev_tail, has_next, next_head, next_tail, last_result,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/sstn_cell.sv =====
// One cell of the table row: holds a single entry, takes its right
// neighbor's entry on rotate, and opens a slot on insert. Uses sstn_pkg.
`default_nettype none

module sstn_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned PosW  = 7
) (
  input  wire                       clk_i,
  input  wire sstn_pkg::cell_ctrl_t ctrl_i,
  input  wire [PosW-1:0]            pos_i,
  input  wire sstn_pkg::entry_t     from_right_i,
  input  wire sstn_pkg::entry_t     from_left_i,
  input  wire sstn_pkg::entry_t     new_i,
  output sstn_pkg::entry_t          entry_o
);

  localparam logic [PosW-1:0] MyIdx = PosW'(Index);

  sstn_pkg::entry_t entry_q;
  sstn_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.rotate) begin
      entry_d = from_right_i;
    end else if (ctrl_i.insert) begin
      if (MyIdx == pos_i) begin
        entry_d = new_i;
      end else if (MyIdx > pos_i) begin
        entry_d = from_left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_score_table_with_neighbours.sv =====
// Sorted score table with neighbor query: control, scan window and a ring
// of sstn_cell instances. Uses sstn_pkg, sstn_in_if, sstn_out_if, sstn_cell.
//
// Usage:
//   in_i carries one word per request: action (add or query), a signed score
//   and a nine-byte name (bytes after the first zero byte are ignored).
//   out_o carries result words; last_result marks the final word of a request.
//   An add yields one word: inserted, duplicate name or table full.
//   A query yields one word per entry with that score, in table order, with
//   the names of its neighbors where present, or a single no-match word.
// Operation:
//   The entries sit in a ring of Capacity cells. Every request rotates the
//   ring once around, looking at entry k through cell 0 with its neighbors
//   in the last cell and cell 1; a finish state follows, in which an add
//   shifts the cells to insert. The next request is accepted once the final
//   word is loaded into the output register.
// Reset:
//   Clears the entry count and the control state; cell contents stay
//   undefined and are never reported before being written.
// Stall:
//   Results leave through one output register. A query that finds a new
//   match while an earlier one still cannot leave holds the ring in place.
`default_nettype none

module sorted_score_table_with_neighbours #(
  parameter int unsigned Capacity = sstn_pkg::CAPACITY_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  sstn_in_if.sink     in_i,
  sstn_out_if.source  out_o
);

  localparam int unsigned IW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam logic [IW-1:0] LastK = IW'(Capacity - 1);
  localparam logic [CW-1:0] CapCount = CW'(Capacity);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Request held for the whole scan.
  logic               action_q;
  logic signed [31:0] key_q;
  sstn_pkg::name_t    name_q;

  logic [IW-1:0] k_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] pos_q;
  logic          dup_q;
  logic          eq0_q;

  logic              pend_valid_q;
  sstn_pkg::result_t pend_q;
  logic              out_valid_q;
  sstn_pkg::result_t out_q;

  // Ring of cells.
  sstn_pkg::entry_t     cells[Capacity];
  sstn_pkg::cell_ctrl_t cell_ctrl;
  sstn_pkg::entry_t     new_entry;
  logic [CW-1:0]        ins_pos;

  assign new_entry.score = key_q;
  assign new_entry.name  = name_q;
  assign ins_pos         = eq0_q ? CW'(1) : pos_q;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    sstn_cell #(
      .Index (g),
      .PosW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .pos_i        (ins_pos),
      .from_right_i (cells[(g + 1) % Capacity]),
      .from_left_i  (cells[(g + Capacity - 1) % Capacity]),
      .new_i        (new_entry),
      .entry_o      (cells[g])
    );
  end

  // Scan window: cell 0 holds entry k, its neighbors sit on either side.
  sstn_pkg::entry_t win, prv, nxt;
  assign win = cells[0];
  assign prv = cells[Capacity-1];
  assign nxt = cells[1];

  logic          in_fire, out_fire, can_load;
  logic          k_valid, key_eq, key_lt, name_eq, hit, stall, step, scan_end;
  logic          has_prev, has_next, do_insert, load_out;
  logic [CW-1:0] k_ext;
  sstn_pkg::result_t cur_res, fin_res, out_d;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign can_load = !out_valid_q || out_o.ready;

  assign k_ext    = CW'(k_q);
  assign k_valid  = k_ext < count_q;
  assign key_eq   = win.score == key_q;
  assign key_lt   = win.score < key_q;
  assign name_eq  = win.name == name_q;
  assign has_prev = k_q != '0;
  assign has_next = (k_ext + CW'(1)) < count_q;

  assign hit      = (state_q == ST_SCAN) && (action_q == sstn_pkg::ACT_QUERY)
                    && k_valid && key_eq;
  // Hold the ring when a second match finds the output register busy.
  assign stall    = hit && pend_valid_q && !can_load;
  assign step     = (state_q == ST_SCAN) && !stall;
  assign scan_end = step && (k_q == LastK);

  assign do_insert = (state_q == ST_FIN) && (action_q == sstn_pkg::ACT_ADD)
                     && !dup_q && (count_q != CapCount) && can_load;

  assign cell_ctrl.rotate = step;
  assign cell_ctrl.insert = do_insert;

  always_comb begin
    cur_res           = '0;
    cur_res.status    = sstn_pkg::STATUS_MATCH;
    cur_res.self_name = win.name;
    cur_res.has_prev  = has_prev;
    cur_res.prev_name = has_prev ? prv.name : '0;
    cur_res.has_next  = has_next;
    cur_res.next_name = has_next ? nxt.name : '0;
  end

  always_comb begin
    fin_res      = '0;
    fin_res.last = 1'b1;
    if (action_q == sstn_pkg::ACT_QUERY) begin
      if (pend_valid_q) begin
        fin_res      = pend_q;
        fin_res.last = 1'b1;
      end else begin
        fin_res.status = sstn_pkg::STATUS_NOMATCH;
      end
    end else begin
      fin_res.self_name = name_q;
      if (dup_q) begin
        fin_res.status = sstn_pkg::STATUS_DUPLICATE;
      end else if (count_q == CapCount) begin
        fin_res.status = sstn_pkg::STATUS_FULL;
      end else begin
        fin_res.status = sstn_pkg::STATUS_INSERTED;
      end
    end
  end

  always_comb begin
    load_out = 1'b0;
    out_d    = fin_res;
    state_d  = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit && pend_valid_q && can_load) begin
          load_out = 1'b1;
          out_d    = pend_q;
        end
        if (scan_end) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (can_load) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      k_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        k_q          <= '0;
        pend_valid_q <= 1'b0;
      end else if (step) begin
        k_q <= k_q + IW'(1);
        if (hit) begin
          pend_valid_q <= 1'b1;
        end
      end
      if (do_insert) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  // Payload and scan accumulators.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= in_i.action;
      key_q    <= in_i.score;
      name_q   <= sstn_pkg::canon_name(in_i.name_head, in_i.name_tail);
      pos_q    <= '0;
      dup_q    <= 1'b0;
      eq0_q    <= 1'b0;
    end else if (step && (action_q == sstn_pkg::ACT_ADD)) begin
      if (k_valid && name_eq) begin
        dup_q <= 1'b1;
      end
      pos_q <= pos_q + CW'(k_valid && key_lt);
      if (k_q == '0) begin
        eq0_q <= k_valid && key_eq;
      end
    end
    if (hit && !stall) begin
      pend_q <= cur_res;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.self_head   = out_q.self_name.head;
  assign out_o.self_tail   = out_q.self_name.tail;
  assign out_o.has_prev    = out_q.has_prev;
  assign out_o.prev_head   = out_q.prev_name.head;
  assign out_o.prev_tail   = out_q.prev_name.tail;
  assign out_o.has_next    = out_q.has_next;
  assign out_o.next_head   = out_q.next_name.head;
  assign out_o.next_tail   = out_q.next_name.tail;
  assign out_o.last_result = out_q.last;

  // The entry count never passes the ring size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("entry count above capacity");

  // An insert only lands on a table with room and bumps the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not advance entry count");

  // The last step of the ring rotation hands over to the finish state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_end |=> state_q == ST_FIN)
    else $error("scan did not finish after a full rotation");

  // A held match exists only while a query is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && state_q != ST_IDLE |-> action_q == sstn_pkg::ACT_QUERY)
    else $error("pending match during an add");

  // The ring never rotates outside the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.rotate |-> state_q == ST_SCAN && !cell_ctrl.insert)
    else $error("ring moved outside the scan");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for sorted_score_table_with_neighbours: drives add and
// query words into in_i, predicts every result word from a shadow table and checks out_o.
// Depends on sstn_pkg, sstn_in_if, sstn_out_if and the block under test.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sstn_pkg::*;

  localparam int unsigned CAPACITY    = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned END_WAIT    = 100_000;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned MAX_REPORTS = 200;

  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

  logic clk;
  logic rst_n;

  sstn_in_if  req_ch ();
  sstn_out_if rsp_ch ();

  sorted_score_table_with_neighbours #(
    .Capacity (CAPACITY)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  // Shadow copy of the table; only entries below shadow_len are ever read.
  entry_t      shadow_table [CAPACITY];
  int unsigned shadow_len = 0;

  // Result words still owed by the block, oldest first.
  result_t     expected_words [$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // While set, neither the sender nor the receiver idles.
  bit          steady_flow = 1'b0;

  // 8 ns clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run: the slowest legal run stays far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: drop ready about 37 percent of the time, never during a steady stretch.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ------------------------------------------------------------------------
  // Name handling
  // ------------------------------------------------------------------------

  // Clear every byte from the first zero byte on; the block stores names that way.
  function automatic name_t trim_name(logic [63:0] head, logic [7:0] tail);
    logic [71:0] raw;
    bit          cut;
    raw = {head, tail};
    cut = 1'b0;
    for (int b = 0; b < 9; b++) begin
      if (raw[71-8*b -: 8] == 8'h00) cut = 1'b1;
      if (cut) raw[71-8*b -: 8] = 8'h00;
    end
    return name_t'(raw);
  endfunction

  // Pack up to nine characters, first character in the top byte.
  function automatic name_t text_name(string s);
    logic [71:0] raw;
    raw = '0;
    for (int b = 0; b < 9 && b < s.len(); b++) raw[71-8*b -: 8] = s[b];
    return name_t'(raw);
  endfunction

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Add: duplicate check first, then full check, then insert at the rank of the
  // score, except that a score equal to entry 0 goes to index 1.
  function automatic void predict_add(logic signed [31:0] score, name_t nm);
    result_t word;
    int      slot;
    bit      dup;
    word = '0;
    word.status    = STATUS_INSERTED;
    word.self_name = nm;
    word.last      = 1'b1;
    dup = 1'b0;
    for (int i = 0; i < int'(shadow_len); i++) begin
      if (shadow_table[i].name == nm) dup = 1'b1;
    end
    if (dup) begin
      word.status = STATUS_DUPLICATE;
    end else if (shadow_len >= CAPACITY) begin
      word.status = STATUS_FULL;
    end else begin
      slot = 0;
      for (int i = 0; i < int'(shadow_len); i++) begin
        if (shadow_table[i].score < score) slot++;
      end
      if (shadow_len > 0 && shadow_table[0].score == score) slot = 1;
      for (int i = int'(shadow_len); i > slot; i--) shadow_table[i] = shadow_table[i-1];
      shadow_table[slot].score = score;
      shadow_table[slot].name  = nm;
      shadow_len++;
    end
    expected_words.push_back(word);
  endfunction

  // Query: one match word per entry with this score, in table order, or one
  // no-match word. Absent neighbors leave their flag and name at zero.
  function automatic void predict_query(logic signed [31:0] score);
    result_t word;
    int      hits;
    hits = 0;
    for (int i = 0; i < int'(shadow_len); i++) begin
      if (shadow_table[i].score == score) begin
        word = '0;
        word.status    = STATUS_MATCH;
        word.self_name = shadow_table[i].name;
        if (i > 0) begin
          word.has_prev  = 1'b1;
          word.prev_name = shadow_table[i-1].name;
        end
        if (i + 1 < int'(shadow_len)) begin
          word.has_next  = 1'b1;
          word.next_name = shadow_table[i+1].name;
        end
        expected_words.push_back(word);
        hits++;
      end
    end
    if (hits == 0) begin
      word = '0;
      word.status = STATUS_NOMATCH;
      word.last   = 1'b1;
      expected_words.push_back(word);
    end else begin
      expected_words[expected_words.size()-1].last = 1'b1;
    end
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      end
    end
  endfunction

  // Compare each accepted result word, field by field, with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: result word with nothing expected: expected none, actual status %0d",
                   $time, rsp_ch.status);
        end
      end else begin
        want = expected_words.pop_front();
        compare_field("status",      64'(want.status),         64'(rsp_ch.status));
        compare_field("self_head",   want.self_name.head,      rsp_ch.self_head);
        compare_field("self_tail",   64'(want.self_name.tail), 64'(rsp_ch.self_tail));
        compare_field("has_prev",    64'(want.has_prev),       64'(rsp_ch.has_prev));
        compare_field("prev_head",   want.prev_name.head,      rsp_ch.prev_head);
        compare_field("prev_tail",   64'(want.prev_name.tail), 64'(rsp_ch.prev_tail));
        compare_field("has_next",    64'(want.has_next),       64'(rsp_ch.has_next));
        compare_field("next_head",   want.next_name.head,      rsp_ch.next_head);
        compare_field("next_tail",   64'(want.next_name.tail), 64'(rsp_ch.next_tail));
        compare_field("last_result", 64'(want.last),           64'(rsp_ch.last_result));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Send one word. Entered and left at a falling edge; valid stays high after
  // acceptance so that a following word goes out without a dip. Predict at the
  // accepting edge, before any result of this word can appear.
  task automatic send_word(logic act, logic signed [31:0] score,
                           logic [63:0] head, logic [7:0] tail);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.action    = act;
    req_ch.score     = score;
    req_ch.name_head = head;
    req_ch.name_tail = tail;
    do @(posedge clk); while (!req_ch.ready);
    if (act == ACT_ADD) predict_add(score, trim_name(head, tail));
    else predict_query(score);
    @(negedge clk);
  endtask

  // Hold the sender until every owed word has come, then let the block settle.
  task automatic drain_results();
    req_ch.valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  // Raw name bits: mostly fresh random names, some cut short by a zero byte,
  // some a stored name with junk after its terminator (a duplicate).
  function automatic logic [71:0] random_name_raw();
    logic [71:0] raw;
    bit          seen;
    raw = {$urandom, $urandom, 8'($urandom)};
    if (shadow_len > 0 && $urandom_range(99) < 15) begin
      raw  = shadow_table[$urandom_range(shadow_len - 1)].name;
      seen = 1'b0;
      for (int b = 0; b < 9; b++) begin
        if (seen) raw[71-8*b -: 8] = 8'($urandom);
        else if (raw[71-8*b -: 8] == 8'h00) seen = 1'b1;
      end
    end else if ($urandom_range(99) < 40) begin
      raw[71-8*$urandom_range(8) -: 8] = 8'h00;
    end
    return raw;
  endfunction

  // Scores from a narrow pool so that ties and multi-match queries are common,
  // with the extremes and full-range values mixed in.
  function automatic logic signed [31:0] pick_score();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return SCORE_MIN;
    if (r < 18) return SCORE_MAX;
    if (r < 40) return 32'(int'($urandom_range(3)) - 1);
    if (r < 55 && shadow_len > 0) return shadow_table[$urandom_range(shadow_len - 1)].score;
    return $urandom;
  endfunction

  task automatic send_random_add();
    logic [71:0] raw;
    raw = random_name_raw();
    send_word(ACT_ADD, pick_score(), raw[71:8], raw[7:0]);
  endtask

  // Queries mostly hit a stored score; the rest may miss.
  task automatic send_random_query();
    logic signed [31:0] score;
    if (shadow_len > 0 && $urandom_range(99) < 65) begin
      score = shadow_table[$urandom_range(shadow_len - 1)].score;
    end else begin
      score = pick_score();
    end
    send_word(ACT_QUERY, score, {$urandom, $urandom}, 8'($urandom));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Queries on the empty table: a single no-match word each.
  task automatic test_empty_queries();
    send_word(ACT_QUERY, 32'sd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_word(ACT_QUERY, SCORE_MIN, 64'h0, 8'h00);
  endtask

  // Adds at the extremes, names from empty to nine bytes long, and ties with entry 0.
  task automatic test_insert_order();
    name_t nm;
    // Junk after the terminator must vanish from the stored name.
    send_word(ACT_ADD, SCORE_MAX, {"ZED", 8'h00, 32'hA5C3_1F77}, 8'h77);
    send_word(ACT_ADD, SCORE_MIN, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    // Empty name: the tail byte is dropped too.
    send_word(ACT_ADD, 32'sd0, 64'h0, 8'hFF);
    nm = text_name("MINUSONE9");
    send_word(ACT_ADD, -32'sd1, nm.head, nm.tail);
    // Same score as entry 0: goes to index 1, twice over.
    nm = text_name("SECONDMIN");
    send_word(ACT_ADD, SCORE_MIN, nm.head, nm.tail);
    nm = text_name("THIRDMIN");
    send_word(ACT_ADD, SCORE_MIN, nm.head, 8'h3C);
    send_word(ACT_ADD, 32'sd0, 64'h0100_0000_0000_0000 | 64'h0000_C3C3_0000_0000, 8'h80);
    nm = text_name("ZERO2");
    send_word(ACT_ADD, 32'sd0, nm.head, nm.tail);
    send_word(ACT_ADD, 32'sh5555_5555, 64'h55AA_55AA_55AA_55AA, 8'hAA);
  endtask

  // Names already present, some spelled with different junk after the terminator.
  task automatic test_duplicates();
    send_word(ACT_ADD, 32'sd5, {"ZED", 8'h00, 32'h1234_5678}, 8'h01);
    send_word(ACT_ADD, 32'sd7, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_word(ACT_ADD, SCORE_MAX, 64'h0, 8'h5A);
  endtask

  // First and last entries, multi-match scores and a miss.
  task automatic test_directed_queries();
    send_word(ACT_QUERY, SCORE_MIN, 64'h0, 8'h00);
    send_word(ACT_QUERY, SCORE_MAX, 64'h0, 8'h00);
    send_word(ACT_QUERY, 32'sd0, 64'h0, 8'h00);
    send_word(ACT_QUERY, -32'sd1, 64'h0, 8'h00);
    send_word(ACT_QUERY, 32'sh5555_5555, 64'h0, 8'h00);
    send_word(ACT_QUERY, 32'sd7, 64'h0, 8'h00);
  endtask

  // Random adds and queries on a filling table, with one steady stretch and
  // one pause for the results to drain.
  task automatic test_random_mix(int unsigned words);
    for (int unsigned n = 0; n < words; n++) begin
      if (n == words / 4) steady_flow = 1'b1;
      if (n == words / 4 + 50) steady_flow = 1'b0;
      if (n == words / 2) drain_results();
      if ($urandom_range(99) < 55) send_random_add();
      else send_random_query();
    end
  endtask

  // Add until the shadow table holds CAPACITY entries.
  task automatic test_fill_to_capacity();
    while (shadow_len < CAPACITY) send_random_add();
  endtask

  // On a full table: new names report full, stored names still report duplicate,
  // and queries may match many entries.
  task automatic test_full_table(int unsigned words);
    logic [71:0] raw;
    for (int unsigned n = 0; n < words; n++) begin
      case ($urandom_range(2))
        0: begin
          send_random_query();
        end
        1: begin
          raw = shadow_table[$urandom_range(shadow_len - 1)].name;
          send_word(ACT_ADD, pick_score(), raw[71:8], raw[7:0]);
        end
        default: begin
          send_random_add();
        end
      endcase
    end
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_ADD;
    req_ch.score     = '0;
    req_ch.name_head = '0;
    req_ch.name_tail = '0;
    rst_n            = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_queries();
    test_insert_order();
    test_duplicates();
    test_directed_queries();
    drain_results();
    test_random_mix(200);
    test_fill_to_capacity();
    test_full_table(100);

    // Let every owed word arrive, then give the block a full pass to misbehave.
    req_ch.valid = 1'b0;
    for (int unsigned w = 0; w < END_WAIT && expected_words.size() != 0; w++) begin
      @(posedge clk);
    end
    repeat (CAPACITY + 8) @(posedge clk);

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_words.size() != 0) begin
        $display("%0t: %0d result words never arrived", $time, expected_words.size());
      end
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sorted_score_table_with_neighbours.f =====
rtl/sstn_pkg.sv
rtl/sstn_if.sv
rtl/sstn_cell.sv
rtl/sorted_score_table_with_neighbours.sv
tb/tb_top.sv
